### hdl/ihist_pkg.sv
// Shared types and codes for the integer histogram block.
package ihist_pkg;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic CFG_LOW_BOUND  = 1'b0;
    localparam logic CFG_HIGH_BOUND = 1'b1;

    typedef enum logic [1:0] {
        PLACE_BIN   = 2'd0,
        PLACE_BELOW = 2'd1,
        PLACE_ABOVE = 2'd2,
        PLACE_OOR   = 2'd3
    } t_place;

    // bin store control: read issued at accept, increment in the update stage
    typedef struct packed {
        logic rd_en;
        logic inc;
    } t_bin_ctl;

    // statistics update from the update stage
    typedef struct packed {
        logic   rec;
        t_place place;
    } t_stat_upd;

endpackage

### hdl/ihist_bins.sv
// Bin count memory with post-reset clear, write bypass and saturating increment.
module ihist_bins #(
    parameter int BIN_DEPTH  = 64,
    parameter int COUNT_BITS = 32,
    localparam int ABITS     = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ihist_pkg::t_bin_ctl   i_ctl,
    input  logic [ABITS-1:0]      i_rd_addr,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_busy
);

    logic [COUNT_BITS-1:0] r_mem [BIN_DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [COUNT_BITS-1:0] r_byp_data;
    logic [ABITS-1:0]      r_addr;
    logic [ABITS-1:0]      r_clr_addr;
    logic                  r_byp;
    logic                  r_clr;
    logic [COUNT_BITS-1:0] n_old;
    logic [COUNT_BITS-1:0] n_val;

    // previous beat wrote the entry on the same edge this one was read
    assign n_old   = r_byp ? r_byp_data : r_rdata;
    assign n_val   = (&n_old) ? n_old : n_old + 1'b1;
    assign o_count = i_ctl.inc ? n_val : n_old;
    assign o_busy  = r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_byp      <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ABITS'(BIN_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_byp <= i_ctl.inc && i_ctl.rd_en && (i_rd_addr == r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.inc) begin
            r_mem[r_addr] <= n_val;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
            r_addr  <= i_rd_addr;
        end
        r_byp_data <= n_val;
    end

endmodule

### hdl/ihist_stats.sv
// Total, outlier counters and running min/max.
module ihist_stats #(
    parameter int COUNT_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ihist_pkg::t_stat_upd   i_upd,
    input  logic signed [15:0]     i_sample,
    output logic [COUNT_BITS-1:0]  o_total,
    output logic [COUNT_BITS-1:0]  o_below,
    output logic [COUNT_BITS-1:0]  o_above,
    output logic [COUNT_BITS-1:0]  o_outlier,
    output logic signed [15:0]     o_min,
    output logic signed [15:0]     o_max
);

    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_below;
    logic [COUNT_BITS-1:0] r_above;
    logic signed [15:0]    r_min;
    logic signed [15:0]    r_max;
    logic [COUNT_BITS-1:0] n_total;
    logic [COUNT_BITS-1:0] n_below;
    logic [COUNT_BITS-1:0] n_above;
    logic                  n_first;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    assign n_total   = sat_inc(r_total);
    assign n_below   = sat_inc(r_below);
    assign n_above   = sat_inc(r_above);
    assign n_first   = (r_total == '0);
    assign o_outlier = (i_upd.place == ihist_pkg::PLACE_BELOW) ? n_below : n_above;

    assign o_total = r_total;
    assign o_below = r_below;
    assign o_above = r_above;
    assign o_min   = r_min;
    assign o_max   = r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_below <= '0;
            r_above <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_upd.rec) begin
            r_total <= n_total;
            if (i_upd.place == ihist_pkg::PLACE_BELOW) begin
                r_below <= n_below;
            end
            if (i_upd.place == ihist_pkg::PLACE_ABOVE) begin
                r_above <= n_above;
            end
            if (n_first || (i_sample < r_min)) begin
                r_min <= i_sample;
            end
            if (n_first || (i_sample > r_max)) begin
                r_max <= i_sample;
            end
        end
    end

endmodule

### hdl/integer_histogram_with_outliers.sv
// Integer histogram with below/above outlier counters: top level.
// Result strobe follows the accept edge through the classify and update registers.
// Throughput: one beat per cycle while busy is low; bin read-modify-write is bypassed back to back.
// Reset: synchronous; afterwards busy stays high while the bin memory is
// cleared one entry per cycle. Config writes are taken at any time.
// Results are strobed for one cycle; the receiver cannot stall.
module integer_histogram_with_outliers #(
    parameter int BIN_DEPTH  = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic signed [15:0] i_sample_value,
    input  logic [5:0]         i_bin_index,
    output logic               o_strobe,
    output logic [31:0]        o_hit_count,
    output logic [31:0]        o_samples_seen,
    output logic [31:0]        o_below_seen,
    output logic [31:0]        o_above_seen,
    output logic signed [15:0] o_smallest,
    output logic signed [15:0] o_largest,
    output logic [1:0]         o_placement
);

    localparam int ABITS = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;

    logic signed [15:0]    r_low;
    logic signed [15:0]    r_high;

    logic                  r_a_valid;
    logic                  r_a_act;
    ihist_pkg::t_place     r_a_place;
    logic signed [15:0]    r_a_sample;

    logic                  r_strobe;
    logic [31:0]           r_hit;
    ihist_pkg::t_place     r_place;

    logic                  n_accept;
    logic signed [16:0]    n_diff;
    logic signed [17:0]    n_rd_sum;
    logic                  n_in_cap;
    logic                  n_rd_ok;
    ihist_pkg::t_place     n_place;
    logic [ABITS-1:0]      n_addr;
    logic [31:0]           n_hit;

    ihist_pkg::t_bin_ctl   bin_ctl;
    ihist_pkg::t_stat_upd  stat_upd;
    logic [COUNT_BITS-1:0] bin_count;
    logic                  bin_busy;
    logic [COUNT_BITS-1:0] st_total;
    logic [COUNT_BITS-1:0] st_below;
    logic [COUNT_BITS-1:0] st_above;
    logic [COUNT_BITS-1:0] st_outlier;

    assign busy     = bin_busy;
    assign n_accept = start && !bin_busy;

    // ---- config ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 16'sd0;
            r_high <= 16'sd63;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ihist_pkg::CFG_LOW_BOUND:  r_low  <= i_cfg_data;
                ihist_pkg::CFG_HIGH_BOUND: r_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- classify ----
    always_comb begin
        n_diff   = $signed({i_sample_value[15], i_sample_value}) - $signed({r_low[15], r_low});
        n_in_cap = !n_diff[16] && (n_diff <= $signed(17'(BIN_DEPTH - 1)));
        n_rd_sum = $signed({{2{r_low[15]}}, r_low}) + $signed({12'd0, i_bin_index});
        n_rd_ok  = (n_rd_sum <= $signed({{2{r_high[15]}}, r_high}))
                   && (32'(i_bin_index) < 32'(BIN_DEPTH));
        if (i_action == ihist_pkg::ACT_READ) begin
            n_addr  = ABITS'(i_bin_index);
            n_place = n_rd_ok ? ihist_pkg::PLACE_BIN : ihist_pkg::PLACE_OOR;
        end else begin
            n_addr = ABITS'(n_diff);
            if (n_diff[16]) begin
                n_place = ihist_pkg::PLACE_BELOW;
            end else if (n_in_cap && (i_sample_value <= r_high)) begin
                n_place = ihist_pkg::PLACE_BIN;
            end else begin
                n_place = ihist_pkg::PLACE_ABOVE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_a_act    <= i_action;
            r_a_place  <= n_place;
            r_a_sample <= i_sample_value;
        end
    end

    // ---- update ----
    assign bin_ctl.rd_en = n_accept;
    assign bin_ctl.inc   = r_a_valid && (r_a_act == ihist_pkg::ACT_RECORD)
                           && (r_a_place == ihist_pkg::PLACE_BIN);
    assign stat_upd.rec   = r_a_valid && (r_a_act == ihist_pkg::ACT_RECORD);
    assign stat_upd.place = r_a_place;

    ihist_bins #(
        .BIN_DEPTH  (BIN_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_bins (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (bin_ctl),
        .i_rd_addr (n_addr),
        .o_count   (bin_count),
        .o_busy    (bin_busy)
    );

    ihist_stats #(
        .COUNT_BITS (COUNT_BITS)
    ) u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (stat_upd),
        .i_sample  (r_a_sample),
        .o_total   (st_total),
        .o_below   (st_below),
        .o_above   (st_above),
        .o_outlier (st_outlier),
        .o_min     (o_smallest),
        .o_max     (o_largest)
    );

    always_comb begin
        case (r_a_place)
            ihist_pkg::PLACE_BIN:   n_hit = 32'(bin_count);
            ihist_pkg::PLACE_BELOW: n_hit = 32'(st_outlier);
            ihist_pkg::PLACE_ABOVE: n_hit = 32'(st_outlier);
            default:                n_hit = '0;
        endcase
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_hit   <= n_hit;
            r_place <= r_a_place;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_hit_count    = r_hit;
    assign o_placement    = r_place;
    assign o_samples_seen = 32'(st_total);
    assign o_below_seen   = 32'(st_below);
    assign o_above_seen   = 32'(st_above);

    // ---- assertions ----
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("accepted beat produced no result strobe");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_placement == ihist_pkg::PLACE_OOR)) |-> (o_hit_count == 32'd0))
        else $error("out-of-range read returned nonzero count");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_total != '0) |-> (o_smallest <= o_largest))
        else $error("smallest exceeds largest");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!r_a_valid && !bin_ctl.inc))
        else $error("bin update during memory clear");

endmodule
